// ----- rtl/doa_pkg.sv -----
// Shared types, widths and the arctangent table of the two-antenna phase estimator.
package doa_pkg;

   // Field and accumulator widths.
   localparam int SAMPLE_BITS  = 16;
   localparam int PROD_W       = 2 * SAMPLE_BITS;
   localparam int COUNT_W      = 13;
   localparam int MAX_VECTOR   = 4096;
   localparam int SUM_W        = 29;
   localparam int CROSS_W      = 46;
   localparam int CROSS_LO_W   = CROSS_W / 2;
   localparam int CROSS_HI_W   = CROSS_W - CROSS_LO_W;
   localparam int MUL_W        = SUM_W + 1;
   localparam int MPROD_W      = 2 * MUL_W;
   localparam int DW           = 64;
   localparam int ANG_W        = 34;
   localparam int ANGLE_W      = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam int REQ_W        = 4 * SAMPLE_BITS;
   localparam logic [COUNT_W-1:0] LEN_RESET = COUNT_W'(64);

   // Operations of the final covariance sequence, one multiply each.
   typedef enum logic [2:0] {
      MUL_DR_LO,
      MUL_DR_HI,
      MUL_DR_S_RR,
      MUL_DR_S_II,
      MUL_DI_LO,
      MUL_DI_HI,
      MUL_DI_S_IR,
      MUL_DI_S_RI
   } mul_op_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_MUL,
      ST_MUL_LAST,
      ST_LOAD,
      ST_SCALE,
      ST_ROTATE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic               sample_valid;
      logic               clear_acc;
      logic               mul_valid;
      mul_op_type         mul_op;
      logic [COUNT_W-1:0] count;
      logic               cordic_load;
      logic               clear_sums;
      logic               prescale;
      logic               prerot;
      logic               rotate;
      logic [ITER_W-1:0]  iter;
      logic               out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic degenerate;
      logic needs_scale;
   } status_type;

   // Arctangent of 2^-i in units of pi/2^31.
   function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/doa_datapath.sv -----
// Datapath: sample accumulators, shared covariance multiplier, CORDIC and output register.
module doa_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  doa_pkg::cmd_type                  cmd,
   input  logic [doa_pkg::REQ_W-1:0]         sample_data,
   output doa_pkg::status_type               status,
   output logic signed [doa_pkg::ANGLE_W-1:0] angle,
   output logic                              degenerate
);
   import doa_pkg::*;

   logic signed [SAMPLE_BITS-1:0] a, b, c, d;
   logic signed [PROD_W-1:0] ac_ff, bd_ff, bc_ff, ad_ff;
   logic signed [PROD_W-1:0] ac_in, bd_in, bc_in, ad_in;
   logic signed [SAMPLE_BITS-1:0] a_ff, b_ff, c_ff, d_ff;
   logic sample_pend_ff, sample_pend_in;

   logic signed [SUM_W-1:0] s0r_ff, s0i_ff, s1r_ff, s1i_ff;
   logic signed [SUM_W-1:0] s0r_in, s0i_in, s1r_in, s1i_in;
   logic signed [CROSS_W-1:0] cr_ff, ci_ff, cr_in, ci_in;
   logic signed [PROD_W:0] cr_term, ci_term;

   logic signed [MUL_W-1:0] op_a, op_b, n_op;
   logic signed [MPROD_W-1:0] mprod_ff, mprod_in;
   mul_op_type op_ff, op_in;
   logic mprod_pend_ff, mprod_pend_in;
   logic signed [DW-1:0] term, dr_ff, di_ff, dr_in, di_in;

   logic signed [DW-1:0] x_ff, y_ff, x_in, y_in, dx, dy;
   logic signed [ANG_W-1:0] ang_ff, ang_in, atan_val;
   logic deg_pend_ff, deg_pend_in;
   logic [ANG_W-1:0] ang_round;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic degenerate_ff, degenerate_in;

   assign a = sample_data[SAMPLE_BITS-1:0];
   assign b = sample_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign c = sample_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
   assign d = sample_data[4*SAMPLE_BITS-1:3*SAMPLE_BITS];

   // Sample products, registered ahead of the accumulators.
   always_comb begin
      ac_in = a * c;
      bd_in = b * d;
      bc_in = b * c;
      ad_in = a * d;
      sample_pend_in = cmd.sample_valid;
   end

   // Running sums of samples and of x0 * conj(x1).
   always_comb begin
      cr_term = (PROD_W+1)'(ac_ff) + (PROD_W+1)'(bd_ff);
      ci_term = (PROD_W+1)'(bc_ff) - (PROD_W+1)'(ad_ff);
      s0r_in = s0r_ff;
      s0i_in = s0i_ff;
      s1r_in = s1r_ff;
      s1i_in = s1i_ff;
      cr_in  = cr_ff;
      ci_in  = ci_ff;
      if (cmd.clear_sums) begin
         s0r_in = '0;
         s0i_in = '0;
         s1r_in = '0;
         s1i_in = '0;
         cr_in  = '0;
         ci_in  = '0;
      end else if (sample_pend_ff) begin
         s0r_in = s0r_ff + SUM_W'(a_ff);
         s0i_in = s0i_ff + SUM_W'(b_ff);
         s1r_in = s1r_ff + SUM_W'(c_ff);
         s1i_in = s1i_ff + SUM_W'(d_ff);
         cr_in  = cr_ff + CROSS_W'(cr_term);
         ci_in  = ci_ff + CROSS_W'(ci_term);
      end
   end

   // Operand selection of the shared covariance multiplier.
   always_comb begin
      n_op = $signed({{(MUL_W-COUNT_W){1'b0}}, cmd.count});
      op_a = n_op;
      op_b = '0;
      case (cmd.mul_op)
         MUL_DR_LO: begin
            op_b = $signed({{(MUL_W-CROSS_LO_W){1'b0}}, cr_ff[CROSS_LO_W-1:0]});
         end
         MUL_DR_HI: begin
            op_b = MUL_W'($signed(cr_ff[CROSS_W-1:CROSS_LO_W]));
         end
         MUL_DR_S_RR: begin
            op_a = MUL_W'(s0r_ff);
            op_b = MUL_W'(s1r_ff);
         end
         MUL_DR_S_II: begin
            op_a = MUL_W'(s0i_ff);
            op_b = MUL_W'(s1i_ff);
         end
         MUL_DI_LO: begin
            op_b = $signed({{(MUL_W-CROSS_LO_W){1'b0}}, ci_ff[CROSS_LO_W-1:0]});
         end
         MUL_DI_HI: begin
            op_b = MUL_W'($signed(ci_ff[CROSS_W-1:CROSS_LO_W]));
         end
         MUL_DI_S_IR: begin
            op_a = MUL_W'(s0i_ff);
            op_b = MUL_W'(s1r_ff);
         end
         MUL_DI_S_RI: begin
            op_a = MUL_W'(s0r_ff);
            op_b = MUL_W'(s1i_ff);
         end
         default: begin
            op_b = '0;
         end
      endcase
      mprod_in      = op_a * op_b;
      op_in         = cmd.mul_op;
      mprod_pend_in = cmd.mul_valid;
   end

   // Accumulate the registered product into the real or imaginary part of D.
   always_comb begin
      term  = DW'(mprod_ff);
      dr_in = dr_ff;
      di_in = di_ff;
      if ((op_ff == MUL_DR_HI) || (op_ff == MUL_DI_HI)) begin
         term = DW'(mprod_ff) <<< CROSS_LO_W;
      end
      if (cmd.clear_acc) begin
         dr_in = '0;
         di_in = '0;
      end else if (mprod_pend_ff) begin
         case (op_ff)
            MUL_DR_LO, MUL_DR_HI:     dr_in = dr_ff + term;
            MUL_DR_S_RR, MUL_DR_S_II: dr_in = dr_ff - term;
            MUL_DI_LO, MUL_DI_HI:     di_in = di_ff + term;
            MUL_DI_S_IR:              di_in = di_ff - term;
            MUL_DI_S_RI:              di_in = di_ff + term;
            default:                  dr_in = dr_ff;
         endcase
      end
   end

   // CORDIC vectoring: prescale, quarter-turn pre-rotation, then one iteration per cycle.
   always_comb begin
      dx       = y_ff >>> cmd.iter;
      dy       = x_ff >>> cmd.iter;
      atan_val = ANG_W'($signed(atan_lookup(5'(cmd.iter))));
      x_in     = x_ff;
      y_in     = y_ff;
      ang_in   = ang_ff;
      deg_pend_in = deg_pend_ff;
      if (cmd.cordic_load) begin
         x_in   = dr_ff;
         y_in   = -di_ff;
         ang_in = '0;
         deg_pend_in = status.degenerate;
      end else if (cmd.prescale) begin
         x_in = x_ff >>> 1;
         y_in = y_ff >>> 1;
      end else if (cmd.prerot) begin
         if (x_ff[DW-1]) begin
            if (!y_ff[DW-1]) begin
               x_in   = y_ff;
               y_in   = -x_ff;
               ang_in = ANG_W'(1) <<< 30;
            end else begin
               x_in   = -y_ff;
               y_in   = x_ff;
               ang_in = -(ANG_W'(1) <<< 30);
            end
         end
      end else if (cmd.rotate) begin
         if (!y_ff[DW-1]) begin
            x_in   = x_ff + dx;
            y_in   = y_ff - dy;
            ang_in = ang_ff + atan_val;
         end else begin
            x_in   = x_ff - dx;
            y_in   = y_ff + dy;
            ang_in = ang_ff - atan_val;
         end
      end
   end

   // Round half up to pi/32768 units and load the result register.
   always_comb begin
      ang_round     = ang_ff + (ANG_W'(1) <<< 15);
      angle_in      = angle_ff;
      degenerate_in = degenerate_ff;
      if (cmd.out_load) begin
         degenerate_in = deg_pend_ff;
         angle_in      = deg_pend_ff ? '0 : $signed(ang_round[ANGLE_W+15:16]);
      end
   end

   // Status for the controller.
   always_comb begin
      status.degenerate  = (dr_ff == '0) && (di_ff == '0);
      status.needs_scale = !((x_ff[DW-1:DW-4] == 4'b0000) || (x_ff[DW-1:DW-4] == 4'b1111))
                        || !((y_ff[DW-1:DW-4] == 4'b0000) || (y_ff[DW-1:DW-4] == 4'b1111));
   end

   // Control flags of the datapath pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_pend_ff <= 1'b0;
         mprod_pend_ff  <= 1'b0;
      end else begin
         sample_pend_ff <= sample_pend_in;
         mprod_pend_ff  <= mprod_pend_in;
      end
   end

   // Accumulators start from zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0r_ff <= '0;
         s0i_ff <= '0;
         s1r_ff <= '0;
         s1i_ff <= '0;
         cr_ff  <= '0;
         ci_ff  <= '0;
      end else begin
         s0r_ff <= s0r_in;
         s0i_ff <= s0i_in;
         s1r_ff <= s1r_in;
         s1i_ff <= s1i_in;
         cr_ff  <= cr_in;
         ci_ff  <= ci_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ac_ff         <= ac_in;
      bd_ff         <= bd_in;
      bc_ff         <= bc_in;
      ad_ff         <= ad_in;
      a_ff          <= a;
      b_ff          <= b;
      c_ff          <= c;
      d_ff          <= d;
      mprod_ff      <= mprod_in;
      op_ff         <= op_in;
      dr_ff         <= dr_in;
      di_ff         <= di_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      ang_ff        <= ang_in;
      deg_pend_ff   <= deg_pend_in;
      angle_ff      <= angle_in;
      degenerate_ff <= degenerate_in;
   end

   assign angle      = angle_ff;
   assign degenerate = degenerate_ff;

endmodule

// ----- rtl/doa_ctrl.sv -----
// Controller: length register, sample count and the sequence of the final computation.
module doa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [doa_pkg::COUNT_W-1:0]   csr_wr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  doa_pkg::status_type           status,
   output doa_pkg::cmd_type              cmd
);
   import doa_pkg::*;

   state_type state_ff, state_in;
   logic [COUNT_W-1:0] len_ff, len_in, len_eff, count_ff, count_in, count_next;
   logic [2:0] step_ff, step_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic out_valid_ff, out_valid_in;
   logic accept;

   // Clamp the configured length to the supported range.
   always_comb begin
      len_in = csr_wr_en ? csr_wr_data : len_ff;
      if (len_ff == '0) begin
         len_eff = COUNT_W'(1);
      end else if (len_ff > COUNT_W'(MAX_VECTOR)) begin
         len_eff = COUNT_W'(MAX_VECTOR);
      end else begin
         len_eff = len_ff;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      iter_in    = iter_ff;
      count_next = count_ff + COUNT_W'(1);
      req_tready = 1'b0;
      accept     = 1'b0;
      cmd              = '0;
      cmd.count        = count_ff;
      cmd.mul_op       = mul_op_type'(step_ff);
      cmd.iter         = iter_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            cmd.sample_valid = accept;
            if (accept) begin
               count_in = count_next;
               if (count_next >= len_eff) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            cmd.clear_acc = 1'b1;
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_valid = 1'b1;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = ST_MUL_LAST;
            end
         end
         ST_MUL_LAST: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.cordic_load = 1'b1;
            cmd.clear_sums  = 1'b1;
            count_in = '0;
            iter_in  = '0;
            state_in = status.degenerate ? ST_FINISH : ST_SCALE;
         end
         ST_SCALE: begin
            if (status.needs_scale) begin
               cmd.prescale = 1'b1;
            end else begin
               cmd.prerot = 1'b1;
               state_in   = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
      out_valid_in = (out_valid_ff && !rsp_tready) || cmd.out_load;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         len_ff       <= LEN_RESET;
         count_ff     <= '0;
         step_ff      <= '0;
         iter_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         iter_ff      <= iter_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

// ----- rtl/two_channel_doa_phase_estimator_unit.sv -----
// Top level of the two-antenna direction-of-arrival phase estimator.
//
// The req channel takes one complex sample pair per transaction, one sample
// from each antenna. After the configured number of pairs (csr_wr_data,
// clamped to 1..4096, reset value 64) the block forms the mean-removed
// cross covariance and returns its phase negated on the rsp channel: rsp_tdata is
// the angle in units of pi/32768, rsp_tuser flags a zero cross covariance
// (angle then 0).
// Samples are taken one per cycle while a vector accumulates. After the last
// pair of a vector, req_tready stays low through a pipeline drain, eight
// passes of the shared multiplier that forms D plus a wait for the last
// product, the CORDIC load, any prescaling, the quarter-turn, 16 CORDIC
// iterations and the output load. A degenerate vector skips the CORDIC iterations.
// The result sits in an output register, so the next vector accumulates
// while rsp_tready is low; only when a second result is ready before the
// first is taken does the block hold req_tready low until it is.
// Reset clears the sample and cross sums, the sample count and rsp_tvalid and sets the length
// back to 64. Write the length only while the block is idle.
module two_channel_doa_phase_estimator_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [doa_pkg::COUNT_W-1:0]  csr_wr_data,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // ch0_real, ch0_imag, ch1_real, ch1_imag from the lowest bit up
   input  logic [doa_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // angle
   output logic [doa_pkg::ANGLE_W-1:0]  rsp_tdata,
   // degenerate
   output logic                         rsp_tuser
);
   import doa_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic signed [ANGLE_W-1:0] angle;

   doa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd)
   );

   doa_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample_data (req_tdata),
      .status      (status),
      .angle       (angle),
      .degenerate  (rsp_tuser)
   );

   assign rsp_tdata = angle;

   // A degenerate result always carries a zero angle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate result with nonzero angle");

   // The result register is loaded only when its previous transaction is done.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

   // A loaded result is offered on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("loaded result not offered");

   // No sample is taken while the covariance is being resolved.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_valid || cmd.rotate || cmd.cordic_load) |-> !req_tready)
      else $error("sample accepted during final computation");

endmodule
